### rtl/top_five_score_selector_top_macros.svh
// Assertion macros shared by the top five score selector RTL.
`ifndef TOP_FIVE_SCORE_SELECTOR_TOP_MACROS_SVH
`define TOP_FIVE_SCORE_SELECTOR_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante; uses clk and rst_n of the enclosing scope.
`define TFS_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tfs_pkg.sv
// Types and constants shared by the top five score selector.
package tfs_pkg;

    localparam int KEEP_COUNT  = 5;
    localparam int MAX_ITEMS   = 65536;
    localparam int SCORE_W     = 32;
    localparam int INDEX_W     = 16;
    localparam int RANK_W      = 3;
    localparam int CNT_W       = $clog2(MAX_ITEMS);
    localparam int RANK_CNT_W  = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0]      CNT_MAX   = CNT_W'(MAX_ITEMS - 1);
    localparam logic [RANK_CNT_W-1:0] LAST_RANK = RANK_CNT_W'(KEEP_COUNT - 1);
    localparam logic [QPTR_W:0]       QUEUE_FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic [INDEX_W-1:0]        index_t;
    typedef logic [RANK_W-1:0]         rank_t;

    // One score tagged with its position, as it travels front to back.
    typedef struct packed {
        score_t score;
        index_t index;
        logic   last;
    } tfs_item_t;

    // One kept rank.
    typedef struct packed {
        score_t score;
        index_t index;
        logic   valid;
    } tfs_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tfs_queue_status_t;

endpackage

### rtl/tfs_score_if.sv
// Input channel carrying one class score per transaction.
interface tfs_score_if;
    import tfs_pkg::*;

    logic   valid;
    logic   ready;
    score_t score;
    logic   last_item;

    modport source (output valid, output score, output last_item, input ready);
    modport sink   (input valid, input score, input last_item, output ready);
endinterface

### rtl/tfs_result_if.sv
// Output channel carrying one ranked result per transaction.
interface tfs_result_if;
    import tfs_pkg::*;

    logic   valid;
    logic   ready;
    rank_t  rank;
    index_t class_index;
    score_t best_score;
    logic   entry_valid;
    logic   last_result;

    modport source (output valid, output rank, output class_index, output best_score,
                    output entry_valid, output last_result, input ready);
    modport sink   (input valid, input rank, input class_index, input best_score,
                    input entry_valid, input last_result, output ready);
endinterface

### rtl/tfs_front.sv
// Front end: accept scores and tag each with its position in the vector.
module tfs_front (
    input  logic                       clk,
    input  logic                       rst_n,
    tfs_score_if.sink                  scores,
    input  tfs_pkg::tfs_queue_status_t status,
    output logic                       push,
    output tfs_pkg::tfs_item_t         item
);
    import tfs_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign scores.ready = !status.full;
    assign push         = scores.valid && scores.ready;

    assign item.score = scores.score;
    assign item.index = INDEX_W'(cnt_reg);
    assign item.last  = scores.last_item;

    // Restart at the vector end, else count up and hold at the top.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push)
        begin
            if (scores.last_item)
                cnt_next = '0;
            else if (cnt_reg != CNT_MAX)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

### rtl/tfs_queue.sv
`include "top_five_score_selector_top_macros.svh"
// Small FIFO between front and back.
module tfs_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  tfs_pkg::tfs_item_t          push_item,
    input  logic                        pop,
    output tfs_pkg::tfs_item_t          head,
    output tfs_pkg::tfs_queue_status_t  status
);
    import tfs_pkg::*;

    tfs_item_t         qmem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign head         = qmem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QUEUE_FULL_COUNT);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            qmem_reg[wr_ptr_reg] <= push_item;
    end

    `TFS_ASSERT_HOLDS(a_no_overflow, push, !status.full || pop, "push into full queue")
    `TFS_ASSERT_HOLDS(a_no_underflow, pop, !status.empty, "pop from empty queue")

endmodule

### rtl/tfs_back.sv
`include "top_five_score_selector_top_macros.svh"
// Back end: insertion sorter over the kept ranks and result drain buffer.
module tfs_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tfs_pkg::tfs_item_t         head,
    input  tfs_pkg::tfs_queue_status_t status,
    output logic                       pop,
    tfs_result_if.source               results
);
    import tfs_pkg::*;

    tfs_entry_t kept_reg  [KEEP_COUNT];
    tfs_entry_t kept_next [KEEP_COUNT];
    tfs_entry_t ins       [KEEP_COUNT];
    tfs_entry_t drain_reg [KEEP_COUNT];
    tfs_entry_t drain_next[KEEP_COUNT];
    tfs_entry_t new_entry;

    logic [KEEP_COUNT-1:0] cmp;
    logic [KEEP_COUNT-1:0] valid_vec;
    logic                  busy_reg;
    logic                  busy_next;
    logic [RANK_CNT_W-1:0] rank_reg;
    logic [RANK_CNT_W-1:0] rank_next;
    logic                  take;
    logic                  can_load;
    logic                  load;

    assign take     = results.valid && results.ready;
    assign can_load = !busy_reg || (results.ready && rank_reg == LAST_RANK);
    assign pop      = !status.empty && (!head.last || can_load);
    assign load     = pop && head.last;

    assign new_entry.score = head.score;
    assign new_entry.index = head.index;
    assign new_entry.valid = 1'b1;

    // Compare against every rank at once; the first hit is the slot.
    always_comb
    begin
        for (int i = 0; i < KEEP_COUNT; i++)
        begin
            valid_vec[i] = kept_reg[i].valid;
            cmp[i] = !kept_reg[i].valid || ($signed(head.score) > $signed(kept_reg[i].score));
        end
        ins[0] = cmp[0] ? new_entry : kept_reg[0];
        for (int i = 1; i < KEEP_COUNT; i++)
        begin
            if (!cmp[i])
                ins[i] = kept_reg[i];
            else if (!cmp[i-1])
                ins[i] = new_entry;
            else
                ins[i] = kept_reg[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < KEEP_COUNT; i++)
        begin
            if (pop && head.last)
                kept_next[i] = '0;
            else if (pop)
                kept_next[i] = ins[i];
            else
                kept_next[i] = kept_reg[i];
        end
    end

    // Load the finished ranking, or shift it out one rank per transaction.
    always_comb
    begin
        busy_next = busy_reg;
        rank_next = rank_reg;
        for (int i = 0; i < KEEP_COUNT; i++)
            drain_next[i] = drain_reg[i];
        if (load)
        begin
            busy_next = 1'b1;
            rank_next = '0;
            for (int i = 0; i < KEEP_COUNT; i++)
                drain_next[i] = ins[i].valid ? ins[i] : '0;
        end
        else if (take)
        begin
            rank_next = rank_reg + 1'b1;
            if (rank_reg == LAST_RANK)
                busy_next = 1'b0;
            for (int i = 0; i < KEEP_COUNT - 1; i++)
                drain_next[i] = drain_reg[i+1];
            drain_next[KEEP_COUNT-1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEEP_COUNT; i++)
                kept_reg[i] <= '0;
            busy_reg <= 1'b0;
            rank_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < KEEP_COUNT; i++)
                kept_reg[i] <= kept_next[i];
            busy_reg <= busy_next;
            rank_reg <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KEEP_COUNT; i++)
            drain_reg[i] <= drain_next[i];
    end

    assign results.valid       = busy_reg;
    assign results.rank        = RANK_W'(rank_reg);
    assign results.class_index = drain_reg[0].index;
    assign results.best_score  = drain_reg[0].score;
    assign results.entry_valid = drain_reg[0].valid;
    assign results.last_result = (rank_reg == LAST_RANK);

    `TFS_ASSERT_HOLDS(a_valid_prefix, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0, "gap in kept ranks")
    `TFS_ASSERT_NEXT(a_clear_after_last, load, valid_vec == '0, "ranks not cleared after vector end")
    `TFS_ASSERT_HOLDS(a_drain_from_top, $rose(busy_reg), rank_reg == '0, "drain did not start at rank 0")

endmodule

### rtl/top_five_score_selector_top.sv
// Top level of the streaming top five score selector.
//
//  channel   direction  transaction carries
//  -------   ---------  ----------------------------------------------------
//  scores    in         score (signed Q16.16), last_item
//  results   out        rank, class_index, best_score, entry_valid, last_result
//
//  Cycles:  one score is accepted per cycle unless the queue is full; the insertion
//           into the five kept ranks compares against all ranks in parallel.
//  Results: a vector end produces five result transactions, served from a drain
//           buffer while the sorter already works on the next vector.
//  Stalls:  a four-entry queue sits between front and back; a vector end waits in
//           it only while the previous vector's results are still being taken.
//  Reset:   rst_n, asynchronous active low; clears the kept ranks, the position
//           counter, the queue and the drain state at once, with no clearing pass.
module top_five_score_selector_top (
    input  logic         clk,
    input  logic         rst_n,
    tfs_score_if.sink    scores,
    tfs_result_if.source results
);
    import tfs_pkg::*;

    tfs_item_t         push_item;
    tfs_item_t         head;
    tfs_queue_status_t status;
    logic              push;
    logic              pop;

    // Tag each accepted score with its position in the vector.
    tfs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .scores (scores),
        .status (status),
        .push   (push),
        .item   (push_item)
    );

    // Decouple acceptance from ranking and result drain.
    tfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (status)
    );

    // Rank scores and emit the five results at each vector end.
    tfs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .status  (status),
        .pop     (pop),
        .results (results)
    );

endmodule

### tb/top_five_score_selector_top_test.sv
// Self-checking testbench for the streaming top five score selector.
`timescale 1ns / 1ps

module top_five_score_selector_top_test;
    import tfs_pkg::*;

    // One ranked result as it leaves the block.
    typedef struct packed {
        rank_t  rank;
        index_t class_index;
        score_t best_score;
        logic   entry_valid;
        logic   last_result;
    } ranked_result_t;

    // One row of the directed table; pinned rows carry typed-in expectations.
    typedef struct packed {
        score_t score;
        logic   last;
        logic   pinned;
    } directed_row_t;

    typedef enum int {
        FLAVOR_WIDE,
        FLAVOR_TIES,
        FLAVOR_EDGES,
        FLAVOR_RAMP
    } score_flavor_t;

    localparam score_t SCORE_TOP     = 32'sh7FFF_FFFF;
    localparam score_t SCORE_BOTTOM  = 32'sh8000_0000;
    localparam int     DIRECTED_ROWS = 23;
    localparam int     PINNED_COUNT  = 10;
    localparam int     RANDOM_SCORES = 350;
    localparam int     CHOKE_CYCLES  = 400;
    localparam int     DRAIN_CYCLES  = 30;
    localparam int     RUN_LIMIT_NS  = 2_000_000;

    logic clk;
    logic rst_n;

    tfs_score_if  score_ch ();
    tfs_result_if result_ch ();

    top_five_score_selector_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .scores  (score_ch),
        .results (result_ch)
    );

    // Directed table: extremes first (pinned), then ties, zeros, sorted runs.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{SCORE_TOP,          1'b1, 1'b1},   // single score vector, largest value
        '{SCORE_BOTTOM,       1'b1, 1'b1},   // single score vector, smallest value
        '{32'sh0001_0000,     1'b0, 1'b0},   // ties on 1.0: earlier index must stay ahead
        '{32'sh0001_0000,     1'b0, 1'b0},
        '{32'shFFFF_0000,     1'b0, 1'b0},
        '{32'sh0001_0000,     1'b0, 1'b0},
        '{SCORE_TOP,          1'b0, 1'b0},
        '{SCORE_BOTTOM,       1'b0, 1'b0},
        '{32'sh0000_0000,     1'b1, 1'b0},
        '{32'sh0000_0000,     1'b0, 1'b0},   // three zeros: filled zero vs unfilled rank
        '{32'sh0000_0000,     1'b0, 1'b0},
        '{32'sh0000_0000,     1'b1, 1'b0},
        '{32'sh0005_0000,     1'b0, 1'b0},   // exactly five, already descending
        '{32'sh0004_0000,     1'b0, 1'b0},
        '{32'sh0003_0000,     1'b0, 1'b0},
        '{32'sh0002_0000,     1'b0, 1'b0},
        '{32'sh0001_0000,     1'b1, 1'b0},
        '{32'sh0001_0000,     1'b0, 1'b0},   // six ascending: every score displaces rank 0
        '{32'sh0002_0000,     1'b0, 1'b0},
        '{32'sh0003_0000,     1'b0, 1'b0},
        '{32'sh0004_0000,     1'b0, 1'b0},
        '{32'sh0005_0000,     1'b0, 1'b0},
        '{32'sh0006_0000,     1'b1, 1'b0}
    };

    // Typed-in results of the two pinned single score vectors.
    ranked_result_t pinned_ranks [PINNED_COUNT] = '{
        '{3'd0, 16'd0, SCORE_TOP,      1'b1, 1'b0},
        '{3'd1, 16'd0, 32'sh0000_0000, 1'b0, 1'b0},
        '{3'd2, 16'd0, 32'sh0000_0000, 1'b0, 1'b0},
        '{3'd3, 16'd0, 32'sh0000_0000, 1'b0, 1'b0},
        '{3'd4, 16'd0, 32'sh0000_0000, 1'b0, 1'b1},
        '{3'd0, 16'd0, SCORE_BOTTOM,   1'b1, 1'b0},
        '{3'd1, 16'd0, 32'sh0000_0000, 1'b0, 1'b0},
        '{3'd2, 16'd0, 32'sh0000_0000, 1'b0, 1'b0},
        '{3'd3, 16'd0, 32'sh0000_0000, 1'b0, 1'b0},
        '{3'd4, 16'd0, 32'sh0000_0000, 1'b0, 1'b1}
    };

    // Predictor state: the kept ranks and the position of the next score.
    tfs_entry_t       kept_rank [KEEP_COUNT];
    logic [CNT_W-1:0] next_position;
    ranked_result_t   vector_ranking [KEEP_COUNT];

    ranked_result_t expected_ranks [$];

    int  pinned_cursor;
    int  mismatch_count;
    int  results_checked;
    int  scores_taken;
    int  vectors_closed;
    bit  sender_steady;
    bit  results_steady;
    bit  choke_request;

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stop a hung run; a correct run ends far earlier.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("run limit reached with %0d results outstanding", expected_ranks.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_ranking();
        foreach (kept_rank[i])
            kept_rank[i] = '0;
        next_position = '0;
    endfunction

    // Fold one accepted score into the kept ranks; return 1 when it closes a
    // vector, with the five results left in vector_ranking.
    function automatic bit fold_score(input score_t s, input logic last);
        int slot;
        slot = KEEP_COUNT;
        // Take the first rank that is empty or strictly beaten; ties keep the older score.
        for (int i = 0; i < KEEP_COUNT; i++)
            if (slot == KEEP_COUNT &&
                (!kept_rank[i].valid || s > $signed(kept_rank[i].score)))
                slot = i;
        if (slot < KEEP_COUNT)
        begin
            for (int i = KEEP_COUNT - 1; i > slot; i--)
                kept_rank[i] = kept_rank[i - 1];
            kept_rank[slot].score = s;
            kept_rank[slot].index = index_t'(next_position);
            kept_rank[slot].valid = 1'b1;
        end
        // Hold the position counter at its cap on long vectors.
        if (next_position != CNT_MAX)
            next_position++;
        if (!last)
            return 1'b0;
        for (int k = 0; k < KEEP_COUNT; k++)
        begin
            vector_ranking[k].rank        = rank_t'(k);
            vector_ranking[k].class_index = kept_rank[k].valid ? kept_rank[k].index : '0;
            vector_ranking[k].best_score  = kept_rank[k].valid ? kept_rank[k].score : '0;
            vector_ranking[k].entry_valid = kept_rank[k].valid;
            vector_ranking[k].last_result = (k == KEEP_COUNT - 1);
        end
        clear_ranking();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic void report_miss(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s", $time, what);
    endfunction

    function automatic void check_rank(input ranked_result_t got);
        ranked_result_t want;
        if (expected_ranks.size() == 0)
        begin
            report_miss($sformatf("unexpected result: rank %0d index %0d score %h filled %b",
                                  got.rank, got.class_index, got.best_score, got.entry_valid));
            return;
        end
        want = expected_ranks.pop_front();
        results_checked++;
        if (got.rank !== want.rank || got.class_index !== want.class_index ||
            got.best_score !== want.best_score || got.entry_valid !== want.entry_valid ||
            got.last_result !== want.last_result)
            report_miss($sformatf({"result differs (expected/actual): rank %0d/%0d ",
                                   "index %0d/%0d score %h/%h filled %b/%b final %b/%b"},
                                  want.rank, got.rank, want.class_index, got.class_index,
                                  want.best_score, got.best_score, want.entry_valid,
                                  got.entry_valid, want.last_result, got.last_result));
    endfunction

    // Compare every result transaction as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_rank('{result_ch.rank, result_ch.class_index, result_ch.best_score,
                         result_ch.entry_valid, result_ch.last_result});
    end

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // Idle length: mostly none or short, now and then long; zero in steady stretches.
    function automatic int pick_gap(input bit steady);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Vector length: many shorter than the five ranks, a few long ones.
    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return $urandom_range(1, 4);
        if (roll < 8)
            return $urandom_range(5, 12);
        if (roll < 9)
            return $urandom_range(13, 40);
        return KEEP_COUNT;
    endfunction

    function automatic score_t draw_score(input score_flavor_t flavor, input int pos_in_vector);
        int pick;
        pick = $urandom_range(0, 4);
        case (flavor)
            // A handful of values in -2.0 .. 2.0, so ties are frequent.
            FLAVOR_TIES:  return score_t'((pick - 2) * 65536);
            FLAVOR_EDGES:
                case (pick)
                    0:       return SCORE_TOP;
                    1:       return SCORE_BOTTOM;
                    2:       return '0;
                    default: return score_t'($urandom);
                endcase
            // Rising scores: every new one lands at rank 0.
            FLAVOR_RAMP:  return score_t'(pos_in_vector * 32768 - 65536 + pick);
            default:      return score_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Score channel driver
    // ------------------------------------------------------------------
    // Offer one score, hold it until taken, then predict its results.
    task automatic offer_score(input score_t s, input logic last, input bit pinned);
        int gap;
        gap = pick_gap(sender_steady);
        if (gap > 0)
        begin
            score_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        score_ch.valid     <= 1'b1;
        score_ch.score     <= s;
        score_ch.last_item <= last;
        do
            @(posedge clk);
        while (!score_ch.ready);
        scores_taken++;
        if (fold_score(s, last))
        begin
            vectors_closed++;
            for (int k = 0; k < KEEP_COUNT; k++)
            begin
                if (pinned)
                begin
                    expected_ranks.push_back(pinned_ranks[pinned_cursor]);
                    pinned_cursor++;
                end
                else
                    expected_ranks.push_back(vector_ranking[k]);
            end
        end
    endtask

    // Drop valid and wait for a clock edge so the next offer starts in a fresh step.
    task automatic go_quiet();
        score_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering until every predicted result has been taken.
    task automatic wait_for_results();
        go_quiet();
        while (expected_ranks.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result channel driver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (choke_request)
            begin
                // Hold ready low for the requested hold-off so the queue fills and input stalls.
                result_ch.ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
                choke_request = 1'b0;
            end
            else
            begin
                stall = pick_gap(results_steady);
                if (stall > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int            random_scores;
        int            random_vectors;
        int            vector_len;
        int            longest_vector;
        score_flavor_t flavor;

        random_scores  = 0;
        random_vectors = 0;
        longest_vector = 0;
        pinned_cursor  = 0;
        mismatch_count = 0;
        sender_steady  = 1'b0;
        results_steady = 1'b0;
        choke_request  = 1'b0;
        clear_ranking();

        rst_n              <= 1'b0;
        score_ch.valid     <= 1'b0;
        score_ch.score     <= '0;
        score_ch.last_item <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, ties, zeros, short and sorted vectors.
        for (int r = 0; r < DIRECTED_ROWS; r++)
            offer_score(directed_rows[r].score, directed_rows[r].last, directed_rows[r].pinned);

        // Random vectors until the score budget is spent.
        while (random_scores < RANDOM_SCORES)
        begin
            vector_len = pick_length();
            flavor     = score_flavor_t'($urandom_range(0, 3));
            if (vector_len > longest_vector)
                longest_vector = vector_len;
            for (int n = 0; n < vector_len; n++)
                offer_score(draw_score(flavor, n), n == vector_len - 1, 1'b0);
            random_scores += vector_len;
            random_vectors++;

            // Reshuffle the idle pattern now and then, with some steady stretches.
            if (random_vectors % 6 == 0)
            begin
                sender_steady  = ($urandom_range(0, 3) == 0);
                results_steady = ($urandom_range(0, 3) == 0);
            end

            // Back up the result side while scores keep coming.
            if (random_vectors == 8)
            begin
                choke_request = 1'b1;
                sender_steady = 1'b1;
                for (int n = 0; n < 9; n++)
                    offer_score(draw_score(FLAVOR_WIDE, 0), 1'b1, 1'b0);
                for (int n = 0; n < 8; n++)
                    offer_score(draw_score(FLAVOR_EDGES, n), n == 7, 1'b0);
                random_scores += 17;
                sender_steady = 1'b0;
                wait_for_results();
            end

            // Pause the sender until the block has handed over everything.
            if (random_vectors % 15 == 7)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatch_count += expected_ranks.size();

        $display("covered %0d vectors of 1 to %0d scores, %0d scores in all, %0d results checked",
                 vectors_closed, longest_vector, scores_taken, results_checked);
        $display("ties, extremes, unfilled ranks, a long result hold-off, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### top_five_score_selector_top.f
+incdir+rtl
rtl/tfs_pkg.sv
rtl/tfs_score_if.sv
rtl/tfs_result_if.sv
rtl/tfs_front.sv
rtl/tfs_queue.sv
rtl/tfs_back.sv
rtl/top_five_score_selector_top.sv
tb/top_five_score_selector_top_test.sv
